// File: hdl/b2bnw_pkg.sv
// Package for the bound-to-bound net weight block: constants, widths and sequencer states.
package b2bnw_pkg;

    localparam int MAX_PINS_DEF = 16;

    localparam int ID_W   = 16;
    localparam int POS_W  = 32;
    localparam int SIZE_W = 24;
    localparam int OFF_W  = 24;
    localparam int CTR_W  = 33;
    localparam int DIST_W = 34;
    localparam int SEP_W  = 16;
    localparam int WGT_W  = 32;

    // Quotient of 2^25 by the divisor: one bit per divider step.
    localparam int QUO_W = 26;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    localparam int ENTRY_W = ID_W + 2 * CTR_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_CHK,
        ST_DIST,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PUSH,
        ST_NEXT,
        ST_FLUSH
    } state_t;

endpackage

// File: hdl/b2bnw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module b2bnw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/b2bnw_div.sv
// Restoring divider: 2^25 divided by an unsigned divisor, one quotient bit per cycle.
module b2bnw_div
    import b2bnw_pkg::*;
#(
    parameter int DVS_W = 39
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVS_W-1:0]  divisor,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(QUO_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic              num_bit;
    logic [DVS_W:0]    shifted;
    logic              ge;

    // The dividend has only its top bit set.
    assign num_bit = (step_reg == STEP_W'(QUO_W - 1));
    assign shifted = {rem_reg, num_bit};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            step_reg <= STEP_W'(QUO_W - 1);
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            rem_reg  <= ge ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
            quo_reg  <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/b2b_net_weight.sv
// Flow: each accepted pin is stored; the last pin of a net with three or more pins starts
// evaluation. Per axis: a min/max scan reads every pin, a second pass reads each back and
// skips the boundary pins, each inner/boundary pair gets a distance check, and a pair beyond
// the threshold emits a weight (distance, multiply, start, the 26-step divider, hand-off, advance).
// A held m_axis stretches the hand-off; a final flush step sends the last word of the net.
// Throughput: one pin per cycle while collecting; the net's evaluation blocks new pins.
// Reset: asynchronous active-low; clears pin count, overflow flag, threshold and output valid.
// Pin RAM contents are not cleared.
module b2b_net_weight
    import b2bnw_pkg::*;
#(
    parameter int MAX_PINS = MAX_PINS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pin_index, module_x, module_y, module_width, module_height, offset_x, offset_y
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // end_pin, inner_pin, weight
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // axis, truncated
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  cfg_wr_en,
    input  logic [SEP_W-1:0]      cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_PINS + 1);
    localparam int IDX_W = $clog2(MAX_PINS);
    localparam int DVS_W = CNT_W + DIST_W;

    state_t state_reg, state_next;

    logic [SEP_W-1:0]   sep_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               ovf_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               axis_reg;
    logic               end_sel_reg;

    logic [CTR_W-1:0]   lo_c_reg, hi_c_reg, cur_c_reg;
    logic [ID_W-1:0]    lo_id_reg, hi_id_reg, cur_id_reg;
    logic [IDX_W-1:0]   lo_idx_reg, hi_idx_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [QUO_W-1:0]   quo_reg;

    logic               pend_valid_reg;
    logic [OUT_DATA_W-1:0] pend_data_reg;
    logic [OUT_USER_W-1:0] pend_user_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;
    logic               out_last_reg;

    // Input unpacking and centre computation.
    logic [ID_W-1:0]   in_id;
    logic [POS_W-1:0]  in_mx, in_my;
    logic [SIZE_W-1:0] in_w, in_h;
    logic [OFF_W-1:0]  in_ox, in_oy;
    logic [CTR_W-1:0]  in_cx, in_cy;

    assign in_id = s_axis_tdata[15:0];
    assign in_mx = s_axis_tdata[47:16];
    assign in_my = s_axis_tdata[79:48];
    assign in_w  = s_axis_tdata[103:80];
    assign in_h  = s_axis_tdata[127:104];
    assign in_ox = s_axis_tdata[151:128];
    assign in_oy = s_axis_tdata[175:152];

    assign in_cx = {in_mx[POS_W-1], in_mx} + {10'b0, in_w[SIZE_W-1:1]}
                 + {{(CTR_W-OFF_W){in_ox[OFF_W-1]}}, in_ox};
    assign in_cy = {in_my[POS_W-1], in_my} + {10'b0, in_h[SIZE_W-1:1]}
                 + {{(CTR_W-OFF_W){in_oy[OFF_W-1]}}, in_oy};

    logic in_acc, room, last_acc;
    logic [CNT_W-1:0] count_after;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign room          = (count_reg < CNT_W'(MAX_PINS));
    assign count_after   = room ? count_reg + 1'b1 : count_reg;
    assign last_acc      = in_acc && s_axis_tlast;

    // Pin RAM.
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [CTR_W-1:0]   rd_c;
    logic [ID_W-1:0]    rd_id;

    assign ram_raddr = idx_reg;
    assign rd_id     = ram_rdata[ENTRY_W-1 -: ID_W];
    assign rd_c      = axis_reg ? ram_rdata[2*CTR_W-1 -: CTR_W] : ram_rdata[CTR_W-1:0];

    b2bnw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_PINS)
    ) u_ram (
        .clk  (clk),
        .we   (in_acc && room),
        .waddr(count_reg[IDX_W-1:0]),
        .wdata({in_id, in_cy, in_cx}),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Distance to the selected boundary pin.
    logic [CTR_W-1:0]  ref_c;
    logic [DIST_W-1:0] diff, abs_dist;
    logic              dist_ok;

    assign ref_c    = end_sel_reg ? hi_c_reg : lo_c_reg;
    assign diff     = {cur_c_reg[CTR_W-1], cur_c_reg} - {ref_c[CTR_W-1], ref_c};
    assign abs_dist = diff[DIST_W-1] ? DIST_W'(-diff) : diff;
    assign dist_ok  = (abs_dist > {{(DIST_W-SEP_W){1'b0}}, sep_reg});

    logic               div_start, div_done;
    logic [QUO_W-1:0]   div_quo;

    b2bnw_div #(
        .DVS_W(DVS_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (dvs_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    logic out_free, last_idx, skip_idx, pend_move;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign last_idx  = ({{(CNT_W-IDX_W){1'b0}}, idx_reg} == CNT_W'(count_reg - 1'b1));
    assign skip_idx  = (idx_reg == lo_idx_reg) || (idx_reg == hi_idx_reg);
    // Advance the held word into the output register.
    assign pend_move = pend_valid_reg && out_free
                       && (state_reg == ST_PUSH || state_reg == ST_FLUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (last_acc && count_after >= CNT_W'(3))
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = last_idx ? ST_EMIT_RD : ST_SCAN_RD;
            ST_EMIT_RD:  state_next = ST_EMIT_CHK;
            ST_EMIT_CHK: state_next = skip_idx ? ST_NEXT : ST_DIST;
            ST_DIST:     state_next = dist_ok ? ST_MUL : ST_NEXT;
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (!end_sel_reg && !skip_idx)
                begin
                    state_next = ST_DIST;
                end
                else if (!last_idx)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (!axis_reg)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg        <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            axis_reg       <= 1'b0;
            end_sel_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sep_reg <= cfg_wr_data;
            end

            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg     <= '0;
                    axis_reg    <= 1'b0;
                    end_sel_reg <= 1'b0;
                    if (in_acc)
                    begin
                        // Short net: close it at once.
                        if (s_axis_tlast && count_after < CNT_W'(3))
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                        end
                        else
                        begin
                            count_reg <= count_after;
                            if (!room)
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN_CHK:
                begin
                    idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                end
                ST_EMIT_CHK:
                begin
                    end_sel_reg <= 1'b0;
                end
                ST_PUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                end
                ST_NEXT:
                begin
                    if (!end_sel_reg && !skip_idx)
                    begin
                        end_sel_reg <= 1'b1;
                    end
                    else if (!last_idx)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg  <= '0;
                        axis_reg <= 1'b1;
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SCAN_CHK:
            begin
                // Strict compares keep the earliest pin on ties.
                if (idx_reg == '0 || $signed(rd_c) < $signed(lo_c_reg))
                begin
                    lo_c_reg   <= rd_c;
                    lo_id_reg  <= rd_id;
                    lo_idx_reg <= idx_reg;
                end
                if (idx_reg == '0 || $signed(rd_c) > $signed(hi_c_reg))
                begin
                    hi_c_reg   <= rd_c;
                    hi_id_reg  <= rd_id;
                    hi_idx_reg <= idx_reg;
                end
            end
            ST_EMIT_CHK:
            begin
                cur_c_reg  <= rd_c;
                cur_id_reg <= rd_id;
            end
            ST_DIST:
            begin
                dist_reg <= abs_dist;
            end
            ST_MUL:
            begin
                dvs_reg <= {{DIST_W{1'b0}}, CNT_W'(count_reg - 1'b1)}
                           * {{CNT_W{1'b0}}, dist_reg};
            end
            ST_DIV_WAIT:
            begin
                quo_reg <= div_quo;
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_data_reg <= pend_data_reg;
                        out_user_reg <= pend_user_reg;
                        out_last_reg <= 1'b0;
                    end
                    // Quotient never exceeds 2^25, so no saturation is reached.
                    pend_data_reg <= {{(WGT_W-QUO_W){1'b0}}, quo_reg, cur_id_reg,
                                      end_sel_reg ? hi_id_reg : lo_id_reg};
                    pend_user_reg <= {ovf_reg, axis_reg};
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_data_reg <= pend_data_reg;
                    out_user_reg <= pend_user_reg;
                    out_last_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: test/b2b_net_weight_checker.sv
// Checker for the net weight block: predicts weights per net and compares output words.
module b2b_net_weight_checker
    import b2bnw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  m_axis_tlast,
    input  logic                  cfg_wr_en,
    input  logic [SEP_W-1:0]      cfg_wr_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic             axis;
        logic [ID_W-1:0]  end_pin;
        logic [ID_W-1:0]  inner_pin;
        logic [WGT_W-1:0] weight;
        logic             truncated;
        logic             final_result;
    } weight_t;

    weight_t weight_q[$];
    logic [SEP_W-1:0]        sep;
    logic [ID_W-1:0]         net_ids [MAX_PINS_DEF];
    logic signed [CTR_W-1:0] net_cx [MAX_PINS_DEF];
    logic signed [CTR_W-1:0] net_cy [MAX_PINS_DEF];
    int                      net_n;
    logic                    net_over;

    task automatic predict_axis(input logic ax);
        int lo, hi;
        logic signed [CTR_W-1:0] c [MAX_PINS_DEF];
        logic signed [DIST_W:0] d;
        logic [63:0] q;
        weight_t w;
        for (int i = 0; i < net_n; i++)
            c[i] = ax ? net_cy[i] : net_cx[i];
        lo = 0;
        hi = 0;
        for (int i = 1; i < net_n; i++)
        begin
            if (c[i] < c[lo]) lo = i;
            if (c[i] > c[hi]) hi = i;
        end
        for (int i = 0; i < net_n; i++)
        begin
            if (i == lo || i == hi)
                continue;
            for (int e = 0; e < 2; e++)
            begin
                int b;
                b = e ? hi : lo;
                d = c[i] - c[b];
                if (d < 0) d = -d;
                if (d <= sep)
                    continue;
                q = (64'd1 << 25) / (64'(net_n - 1) * 64'(d));
                if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
                w.axis = ax;
                w.end_pin = net_ids[b];
                w.inner_pin = net_ids[i];
                w.weight = q[31:0];
                w.truncated = net_over;
                w.final_result = 1'b0;
                weight_q.push_back(w);
            end
        end
    endtask

    task automatic take_pin(input logic [IN_DATA_W-1:0] d, input logic last);
        int base_count;
        if (net_n < MAX_PINS_DEF)
        begin
            net_ids[net_n] = d[15:0];
            net_cx[net_n] = $signed(d[47:16]) + $signed({1'b0, d[103:81]})
                            + $signed(d[151:128]);
            net_cy[net_n] = $signed(d[79:48]) + $signed({1'b0, d[127:105]})
                            + $signed(d[175:152]);
            net_n++;
        end
        else
            net_over = 1'b1;
        if (!last)
            return;
        base_count = weight_q.size();
        if (net_n >= 3)
        begin
            predict_axis(1'b0);
            predict_axis(1'b1);
            if (weight_q.size() > base_count)
                weight_q[$].final_result = 1'b1;
        end
        net_n = 0;
        net_over = 1'b0;
    endtask

    task automatic compare_word();
        weight_t exp_w;
        if (weight_q.size() == 0)
        begin
            $error("unexpected weight word %h", m_axis_tdata);
            fail_count++;
            return;
        end
        exp_w = weight_q.pop_front();
        if (m_axis_tuser[0] !== exp_w.axis)
        begin
            $error("axis: expected %0d, got %0d", exp_w.axis, m_axis_tuser[0]);
            fail_count++;
        end
        if (m_axis_tdata[15:0] !== exp_w.end_pin)
        begin
            $error("end_pin: expected %0d, got %0d", exp_w.end_pin, m_axis_tdata[15:0]);
            fail_count++;
        end
        if (m_axis_tdata[31:16] !== exp_w.inner_pin)
        begin
            $error("inner_pin: expected %0d, got %0d", exp_w.inner_pin, m_axis_tdata[31:16]);
            fail_count++;
        end
        if (m_axis_tdata[63:32] !== exp_w.weight)
        begin
            $error("weight: expected %h, got %h", exp_w.weight, m_axis_tdata[63:32]);
            fail_count++;
        end
        if (m_axis_tuser[1] !== exp_w.truncated)
        begin
            $error("truncated: expected %0d, got %0d", exp_w.truncated, m_axis_tuser[1]);
            fail_count++;
        end
        if (m_axis_tlast !== exp_w.final_result)
        begin
            $error("final_result: expected %0d, got %0d", exp_w.final_result, m_axis_tlast);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            sep = '0;
            net_n = 0;
            net_over = 1'b0;
            weight_q.delete();
        end
        else
        begin
            // check output before predicting, so a same-edge input cannot feed it
            if (m_axis_tvalid && m_axis_tready)
                compare_word();
            if (s_axis_tvalid && s_axis_tready)
                take_pin(s_axis_tdata, s_axis_tlast);
            if (cfg_wr_en)
                sep = cfg_wr_data;
        end
        pending <= weight_q.size();
    end

endmodule

// File: test/b2b_net_weight_test.sv
// Testbench top for the net weight block: stimulus, configuration and verdict.
module b2b_net_weight_test;
    import b2bnw_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_wr_en;
    logic [SEP_W-1:0]      cfg_wr_data;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    int                    burst_left;
    int                    stall_mode;

    b2b_net_weight u_top (.*);

    b2b_net_weight_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Receiver stalls: phases of always-ready, random, and mostly stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_pin(input logic [15:0] id, input logic [31:0] mx, input logic [31:0] my,
                            input logic [23:0] w, input logic [23:0] h,
                            input logic [23:0] ox, input logic [23:0] oy, input logic last);
        if (burst_left == 0)
        begin
            int gap;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap != 0)
                s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {oy, ox, h, w, my, mx, id};
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // the block may still be scanning a net with no weights
        repeat (3000) @(posedge clk);
    endtask

    task automatic set_sep(input logic [SEP_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Net with pins spread over a scale; small scales keep distances near the threshold.
    task automatic random_net(input int npins, input int scale);
        for (int i = 0; i < npins; i++)
        begin
            logic [31:0] mx, my;
            logic [23:0] w, h, ox, oy;
            if ($urandom_range(0, 9) == 0)
            begin
                mx = $urandom; my = $urandom; w = 24'($urandom); h = 24'($urandom);
                ox = 24'($urandom); oy = 24'($urandom);
            end
            else
            begin
                mx = $urandom_range(0, scale) - scale / 2;
                my = $urandom_range(0, scale) - scale / 2;
                w = 24'($urandom_range(0, scale)); h = 24'($urandom_range(0, scale));
                ox = 24'($urandom_range(0, scale) - scale / 2);
                oy = 24'($urandom_range(0, scale) - scale / 2);
            end
            send_pin(16'($urandom), mx, my, w, h, ox, oy, i == npins - 1);
        end
    endtask

    initial
    begin
        int sent;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes: min/max positions and sizes on a 4-pin net
        send_pin(16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 24'h0, 24'hFF_FFFF,
                 24'h80_0000, 24'h7F_FFFF, 1'b0);
        send_pin(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'h0,
                 24'h7F_FFFF, 24'h80_0000, 1'b0);
        send_pin(16'h1234, 32'h0, 32'h0, 24'h1, 24'h3, 24'h0, 24'h0, 1'b0);
        send_pin(16'h5678, 32'h1, 32'h1, 24'h0, 24'h0, 24'h0, 24'h0, 1'b1);
        // short net: two pins, nothing emitted
        send_pin(16'd1, 32'd0, 32'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        send_pin(16'd2, 32'd500, 32'd500, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
        // coinciding pins, with ties
        for (int i = 0; i < 3; i++)
            send_pin(16'(10 + i), 32'd7, 32'd7, 24'd2, 24'd2, 24'd0, 24'd0, i == 2);
        // distance one: the largest weight, 2^24
        send_pin(16'd20, 32'd0, 32'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        send_pin(16'd21, 32'd1, 32'd1, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        send_pin(16'd22, 32'd2, 32'd2, 24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
        drain();

        // overflow: 18 pins, last two pins dropped
        random_net(18, 4000);
        drain();
        set_sep(16'hFFFF);
        random_net(5, 200000);
        random_net(4, 100);
        drain();
        set_sep(16'd0);
        random_net(16, 1000);
        drain();

        sent = 0;
        while (sent < 215)
        begin
            int np;
            np = $urandom_range(0, 7) == 0 ? $urandom_range(1, 20) : $urandom_range(3, 6);
            random_net(np, $urandom_range(0, 1) ? 2000 : 300000);
            sent += np;
            if ($urandom_range(0, 9) == 0)
            begin
                drain();
                set_sep($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 300)));
            end
        end
        drain();

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
